/* sv/grc_pkg.sv */
// Shared types and constants of the grid raycaster.
package grc_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] CFG_POS_X   = 3'd0;
  localparam logic [2:0] CFG_POS_Y   = 3'd1;
  localparam logic [2:0] CFG_DIR_X   = 3'd2;
  localparam logic [2:0] CFG_DIR_Y   = 3'd3;
  localparam logic [2:0] CFG_PLANE_X = 3'd4;
  localparam logic [2:0] CFG_PLANE_Y = 3'd5;

  localparam logic [7:0] CHEST_CODE      = 8'd5;
  localparam logic [7:0] SHADE_X         = 8'd255;
  localparam logic [7:0] SHADE_Y         = 8'd98;
  localparam logic [7:0] SHADE_CHEST     = 8'd190;
  localparam logic [7:0] SHADE_CHEST_MID = 8'd180;

  // divider operand widths: 2^32 or SCREEN_HEIGHT*2^16 dividend, ray magnitude or distance divisor
  localparam int DVD_W = 33;
  localparam int DVS_W = 26;
  localparam int ROW_W = 16;
  localparam int MC_W  = 8;

  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  typedef struct packed {
    logic       operation;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_column;
    logic [7:0] row_start;
    logic [7:0] row_end;
    logic [7:0] shade;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              wr_ok;
    in_item_t          item;
  } q_entry_t;

  typedef struct packed {
    logic        [20:0] pos_x;
    logic        [20:0] pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
  } cam_t;

endpackage

/* sv/grc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* sv/grc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module grc_div import grc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/grc_front.sv */
// Request intake: classifies requests and queues them for the render engine.
module grc_front import grc_pkg::*; #(
  parameter int MAP_SIZE = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           run,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  output logic           q_valid,
  output q_entry_t       q_entry,
  input  logic           q_pop,
  output logic [QPW:0]   q_count
);

  q_entry_t           fifo_r [QDEPTH];
  logic [QPW-1:0]     wptr_r;
  logic [QPW-1:0]     rptr_r;
  logic [QPW:0]       count_r;
  logic               push;
  logic               pop;
  q_entry_t           entry;

  assign in_ready = run && (count_r < (QPW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    entry       = '0;
    entry.item  = in_data;
    entry.wr_ok = (in_data.operation == OP_WRITE) &&
                  (32'(in_data.cell_x) < 32'(MAP_SIZE)) &&
                  (32'(in_data.cell_y) < 32'(MAP_SIZE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r <= count_r + (QPW+1)'(push) - (QPW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= entry;
    end
  end

  assign q_valid = count_r != '0;
  assign q_entry = fifo_r[rptr_r];
  assign q_count = count_r;

endmodule

/* sv/grc_back.sv */
// Render engine: map clear, map writes, ray setup, DDA walk, wall height and segment output.
module grc_back import grc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int MAP_SIZE      = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cam_t      cam,
  output logic      run,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CELLS = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int LIMIT = 4 * MAP_SIZE + 8;
  localparam int SC_W  = $clog2(LIMIT + 1);
  localparam int HALF  = SCREEN_HEIGHT / 2;
  // column*2^17/SCREEN_WIDTH as column*CX_MUL >> 18, exact for 8-bit columns
  localparam int          CX_SH  = 18;
  localparam logic [31:0] CX_MUL = 32'(((64'd1 << 35) + 64'(SCREEN_WIDTH - 1)) /
                                       64'(SCREEN_WIDTH));

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_CX_W  = 5'd2;
  localparam logic [4:0] ST_MUL_X = 5'd3;
  localparam logic [4:0] ST_MUL_Y = 5'd4;
  localparam logic [4:0] ST_RAY   = 5'd5;
  localparam logic [4:0] ST_DX_GO = 5'd6;
  localparam logic [4:0] ST_DX_W  = 5'd7;
  localparam logic [4:0] ST_DY_GO = 5'd8;
  localparam logic [4:0] ST_DY_W  = 5'd9;
  localparam logic [4:0] ST_SD_X  = 5'd10;
  localparam logic [4:0] ST_SD_Y  = 5'd11;
  localparam logic [4:0] ST_STEP  = 5'd12;
  localparam logic [4:0] ST_CHK   = 5'd13;
  localparam logic [4:0] ST_PERP  = 5'd14;
  localparam logic [4:0] ST_LH_GO = 5'd15;
  localparam logic [4:0] ST_LH_W  = 5'd16;
  localparam logic [4:0] ST_ROWS  = 5'd17;
  localparam logic [4:0] ST_EMIT  = 5'd18;

  logic [4:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r;
  logic [7:0]              col_r;
  logic signed [22:0]      camx_r;
  logic signed [40:0]      prod_r;
  logic signed [25:0]      rx_r, ry_r;
  logic [30:0]             dx_r, dy_r;
  logic [39:0]             sdx_r, sdy_r;
  logic signed [MC_W-1:0]  mx_r, my_r;
  logic [SC_W-1:0]         steps_r;
  logic                    side_r, chest_r;
  logic [23:0]             perp_r;
  logic [ROW_W-1:0]        lh_r, s_r, e_r, qb_r;
  logic [1:0]              band_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [30:0]      delta_sat;
  logic [25:0]      rx_mag, ry_mag;
  logic [39:0]      cx_prod;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr, wr_addr;
  logic [7:0]             ram_wdata, ram_rdata;

  logic                   x_first, oob, at_limit;
  logic signed [MC_W-1:0] nmx, nmy;
  logic [39:0]            perp_full;
  logic [ROW_W-1:0]       half, s_c, e_c;
  logic [ROW_W:0]         e_sum;
  logic [16:0]            fx_mul, fy_mul;
  logic                   multi, slot_free, band_last;
  out_item_t              band;

  grc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  grc_ram #(.WIDTH(8), .DEPTH(CELLS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign run       = state_r != ST_CLR;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign rx_mag    = rx_r[25] ? 26'(-rx_r) : 26'(rx_r);
  assign ry_mag    = ry_r[25] ? 26'(-ry_r) : 26'(ry_r);
  assign delta_sat = (|div_q[DVD_W-1:24]) ? 31'h00FF_FFFF : 31'(div_q[23:0]);
  assign cx_prod   = 40'(col_r) * 40'(CX_MUL);
  assign wr_addr   = AW'(32'(q_entry.item.cell_x) * 32'(MAP_SIZE) +
                         32'(q_entry.item.cell_y));

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_r)
      ST_DX_GO: begin
        div_start = rx_r != '0;
        div_dvd   = DVD_W'(1) << 32;
        div_dvs   = rx_mag;
      end
      ST_DY_GO: begin
        div_start = ry_r != '0;
        div_dvd   = DVD_W'(1) << 32;
        div_dvs   = ry_mag;
      end
      ST_LH_GO: begin
        div_start = perp_r != '0;
        div_dvd   = DVD_W'(SCREEN_HEIGHT) << 16;
        div_dvs   = DVS_W'(perp_r);
      end
      default: begin
      end
    endcase
  end

  // one DDA step; the tie goes to y
  always_comb begin
    x_first   = sdx_r < sdy_r;
    nmx       = x_first ? (rx_r[25] ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
    nmy       = x_first ? my_r : (ry_r[25] ? my_r - 1'b1 : my_r + 1'b1);
    oob       = nmx[MC_W-1] || nmy[MC_W-1] ||
                (nmx >= $signed(MC_W'(MAP_SIZE))) || (nmy >= $signed(MC_W'(MAP_SIZE)));
    ram_raddr = AW'(32'(nmx[MC_W-2:0]) * 32'(MAP_SIZE) + 32'(nmy[MC_W-2:0]));
    at_limit  = steps_r == SC_W'(LIMIT);
  end

  always_comb begin
    ram_we    = (state_r == ST_CLR) ||
                ((state_r == ST_IDLE) && q_valid && q_entry.wr_ok);
    ram_waddr = (state_r == ST_CLR) ? clr_cnt_r : wr_addr;
    ram_wdata = (state_r == ST_CLR) ? 8'd0 : q_entry.item.cell_value;
  end

  always_comb begin
    perp_full = side_r ? sdy_r - 40'(dy_r) : sdx_r - 40'(dx_r);
    fx_mul    = rx_r[25] ? {1'b0, cam.pos_x[15:0]} : 17'h10000 - {1'b0, cam.pos_x[15:0]};
    fy_mul    = ry_r[25] ? {1'b0, cam.pos_y[15:0]} : 17'h10000 - {1'b0, cam.pos_y[15:0]};
    half      = lh_r >> 1;
    s_c       = (32'(half) >= 32'(HALF)) ? '0 : ROW_W'(HALF) - half;
    e_sum     = (ROW_W+1)'(half) + (ROW_W+1)'(HALF);
    e_c       = (32'(e_sum) >= 32'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                    : e_sum[ROW_W-1:0];
  end

  // segment bands
  always_comb begin
    multi      = chest_r && (lh_r >= ROW_W'(4));
    slot_free  = !out_valid_r || out_ready;
    band       = '0;
    band.out_column = col_r;
    band_last  = 1'b1;
    if (!multi) begin
      band.row_start = s_r[7:0];
      band.row_end   = e_r[7:0];
      band.shade     = chest_r ? SHADE_CHEST : (side_r ? SHADE_Y : SHADE_X);
    end else begin
      unique case (band_r)
        2'd0: begin
          band.row_start = s_r[7:0];
          band.row_end   = 8'(s_r + qb_r);
          band.shade     = SHADE_CHEST;
          band_last      = 1'b0;
        end
        2'd1: begin
          band.row_start = 8'(s_r + qb_r);
          band.row_end   = 8'(s_r + (qb_r << 1));
          band.shade     = SHADE_CHEST_MID;
          band_last      = 1'b0;
        end
        default: begin
          band.row_start = 8'(s_r + (qb_r << 1));
          band.row_end   = e_r[7:0];
          band.shade     = SHADE_CHEST;
        end
      endcase
    end
    band.last = band_last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:   if (clr_cnt_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid && (q_entry.item.operation == OP_CAST)) state_nxt = ST_CX_W;
      ST_CX_W:  state_nxt = ST_MUL_X;
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_RAY;
      ST_RAY:   state_nxt = ST_DX_GO;
      ST_DX_GO: state_nxt = div_start ? ST_DX_W : ST_DY_GO;
      ST_DX_W:  if (div_done) state_nxt = ST_DY_GO;
      ST_DY_GO: state_nxt = div_start ? ST_DY_W : ST_SD_X;
      ST_DY_W:  if (div_done) state_nxt = ST_SD_X;
      ST_SD_X:  state_nxt = ST_SD_Y;
      ST_SD_Y:  state_nxt = ST_STEP;
      ST_STEP:  state_nxt = (at_limit || oob) ? ST_PERP : ST_CHK;
      ST_CHK:   state_nxt = (ram_rdata != 8'd0) ? ST_PERP : ST_STEP;
      ST_PERP:  state_nxt = ST_LH_GO;
      ST_LH_GO: state_nxt = div_start ? ST_LH_W : ST_ROWS;
      ST_LH_W:  if (div_done) state_nxt = ST_ROWS;
      ST_ROWS:  state_nxt = ST_EMIT;
      ST_EMIT:  if (slot_free && band_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if ((state_r == ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        col_r   <= q_entry.item.column;
        steps_r <= '0;
        side_r  <= 1'b0;
        chest_r <= 1'b0;
        band_r  <= '0;
      end
      ST_CX_W:  camx_r <= $signed({1'b0, cx_prod[39:CX_SH]}) - 23'sd65536;
      ST_MUL_X: prod_r <= 41'(cam.plane_x) * 41'(camx_r);
      ST_MUL_Y: begin
        rx_r   <= 26'(cam.dir_x) + 26'(prod_r >>> 16);
        prod_r <= 41'(cam.plane_y) * 41'(camx_r);
      end
      ST_RAY:   ry_r <= 26'(cam.dir_y) + 26'(prod_r >>> 16);
      ST_DX_GO: if (rx_r == '0) dx_r <= 31'h4000_0000;
      ST_DX_W:  if (div_done) dx_r <= delta_sat;
      ST_DY_GO: if (ry_r == '0) dy_r <= 31'h4000_0000;
      ST_DY_W:  if (div_done) dy_r <= delta_sat;
      ST_SD_X: begin
        sdx_r <= 40'((48'(fx_mul) * 48'(dx_r)) >> 16);
        mx_r  <= MC_W'(cam.pos_x[20:16]);
      end
      ST_SD_Y: begin
        sdy_r <= 40'((48'(fy_mul) * 48'(dy_r)) >> 16);
        my_r  <= MC_W'(cam.pos_y[20:16]);
      end
      ST_STEP: begin
        if (!at_limit) begin
          steps_r <= steps_r + 1'b1;
          mx_r    <= nmx;
          my_r    <= nmy;
          side_r  <= !x_first;
          if (x_first) begin
            sdx_r <= sdx_r + 40'(dx_r);
          end else begin
            sdy_r <= sdy_r + 40'(dy_r);
          end
        end
      end
      ST_CHK:   chest_r <= ram_rdata == CHEST_CODE;
      ST_PERP:  perp_r <= (|perp_full[39:24]) ? 24'hFF_FFFF : perp_full[23:0];
      ST_LH_GO: if (perp_r == '0) lh_r <= 16'hFFFF;
      ST_LH_W: begin
        if (div_done) begin
          lh_r <= (|div_q[DVD_W-1:16]) ? 16'hFFFF : div_q[15:0];
        end
      end
      ST_ROWS: begin
        s_r  <= s_c;
        e_r  <= e_c;
        qb_r <= (e_c - s_c) >> 2;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_data_r <= band;
          band_r     <= band_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/grid_raycast_column.sv */
// Top level of the grid raycaster: camera registers, intake queue and render engine.
// After reset the map is swept to zero, one cell a cycle, while no request is taken;
// configuration writes are taken at any time. A write request is applied to the map when
// the engine pops it while idle. A cast request walks up to 4*MAP_SIZE+8 map steps, then
// emits its segments (one, or three for a chest with a line height of at least 4). Its
// pace is set by the shared one-bit-a-cycle divider, used up to three times per column
// (two ray reciprocals, wall height), and by the map RAM read in each DDA step. A two-entry
// request queue lets requests arrive while a column is being rendered.
module grid_raycast_column import grc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int MAP_SIZE      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_wdata
);

  cam_t         cam_r;
  logic         run;
  logic         q_valid;
  q_entry_t     q_entry;
  logic         q_pop;
  logic [QPW:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.pos_x   <= 21'd98304;
      cam_r.pos_y   <= 21'd98304;
      cam_r.dir_x   <= 18'sd65536;
      cam_r.dir_y   <= 18'sd0;
      cam_r.plane_x <= 18'sd0;
      cam_r.plane_y <= 18'sd43254;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POS_X:   cam_r.pos_x   <= cfg_wdata;
        CFG_POS_Y:   cam_r.pos_y   <= cfg_wdata;
        CFG_DIR_X:   cam_r.dir_x   <= cfg_wdata[17:0];
        CFG_DIR_Y:   cam_r.dir_y   <= cfg_wdata[17:0];
        CFG_PLANE_X: cam_r.plane_x <= cfg_wdata[17:0];
        CFG_PLANE_Y: cam_r.plane_y <= cfg_wdata[17:0];
        default: begin
        end
      endcase
    end
  end

  grc_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .run      (run),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .q_count  (q_count)
  );

  grc_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAP_SIZE      (MAP_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cam       (cam_r),
    .run       (run),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (QPW+1)'(QDEPTH))
    else $error("request queue overfilled");

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !run |-> (!in_ready && !out_valid))
    else $error("request taken or result shown during map clear");

  a_pop_only_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("engine popped an empty queue");

endmodule

/* tb/tb_grid_raycast_column.sv */
// Testbench for grid_raycast_column: random and directed camera settings, map writes and column casts.
`timescale 1ns / 1ps

module tb_grid_raycast_column;
  import grc_pkg::*;

  localparam longint unsigned DIST_MAX  = 64'hFF_FFFF;
  localparam longint unsigned DELTA_INF = 64'd1 << 30;
  localparam longint unsigned LH_MAX    = 64'hFFFF;

  // Column predictor plus the queue of expected segments.
  class column_scoreboard;
    logic [7:0]         cells [1024];
    logic [20:0]        pos_x, pos_y;
    logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
    out_item_t          segs_due [$];
    int                 errs;

    function new();
      foreach (cells[i]) cells[i] = '0;
      pos_x = 21'd98304;
      pos_y = 21'd98304;
      dir_x = 18'sd65536;
      dir_y = '0;
      plane_x = '0;
      plane_y = 18'sd43254;
      errs = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [20:0] val);
      case (idx)
        CFG_POS_X:   pos_x = val;
        CFG_POS_Y:   pos_y = val;
        CFG_DIR_X:   dir_x = val[17:0];
        CFG_DIR_Y:   dir_y = val[17:0];
        CFG_PLANE_X: plane_x = val[17:0];
        CFG_PLANE_Y: plane_y = val[17:0];
        default: ;
      endcase
    endfunction

    function longint unsigned ray_delta(longint r);
      longint unsigned a, d;
      if (r == 0) return DELTA_INF;
      a = (r < 0) ? -r : r;
      d = (64'd1 << 32) / a;
      return (d > DIST_MAX) ? DIST_MAX : d;
    endfunction

    function void push_seg(logic [7:0] col, longint s, longint e, logic [7:0] sh, logic lst);
      out_item_t o;
      o.out_column = col;
      o.row_start  = s[7:0];
      o.row_end    = e[7:0];
      o.shade      = sh;
      o.last       = lst;
      segs_due.push_back(o);
    endfunction

    function void note_request(in_item_t it);
      longint camx, rx, ry, mx, my, sx, sy, s, e, q;
      longint unsigned dx, dy, sdx, sdy, fx, fy, perp, lh;
      logic [7:0] c;
      bit side, chest;
      if (it.operation == OP_WRITE) begin
        cells[{it.cell_x, it.cell_y}] = it.cell_value;
        return;
      end
      side = 0;
      chest = 0;
      camx = longint'(it.column) * 512 - 65536;
      rx = longint'(dir_x) + ((longint'(plane_x) * camx) >>> 16);
      ry = longint'(dir_y) + ((longint'(plane_y) * camx) >>> 16);
      mx = pos_x >> 16;
      my = pos_y >> 16;
      fx = pos_x[15:0];
      fy = pos_y[15:0];
      dx = ray_delta(rx);
      dy = ray_delta(ry);
      if (rx < 0) begin sx = -1; sdx = (fx * dx) >> 16; end
      else begin sx = 1; sdx = ((65536 - fx) * dx) >> 16; end
      if (ry < 0) begin sy = -1; sdy = (fy * dy) >> 16; end
      else begin sy = 1; sdy = ((65536 - fy) * dy) >> 16; end
      for (int st = 0; st < 136; st++) begin
        // equal side distances step in y
        if (sdx < sdy) begin
          sdx += dx; mx += sx; side = 0;
        end else begin
          sdy += dy; my += sy; side = 1;
        end
        if (mx < 0 || my < 0 || mx >= 32 || my >= 32) break;
        c = cells[mx * 32 + my];
        if (c != 0) begin
          chest = (c == CHEST_CODE);
          break;
        end
      end
      perp = side ? sdy - dy : sdx - dx;
      if (perp > DIST_MAX) perp = DIST_MAX;
      if (perp == 0) lh = LH_MAX;
      else begin
        lh = (64'd256 * 65536) / perp;
        if (lh > LH_MAX) lh = LH_MAX;
      end
      s = 128 - longint'(lh / 2);
      if (s < 0) s = 0;
      e = longint'(lh / 2) + 128;
      if (e >= 256) e = 255;
      if (chest && lh >= 4) begin
        q = (e - s) / 4;
        push_seg(it.column, s, s + q, SHADE_CHEST, 1'b0);
        push_seg(it.column, s + q, s + 2 * q, SHADE_CHEST_MID, 1'b0);
        push_seg(it.column, s + 2 * q, e, SHADE_CHEST, 1'b1);
      end else if (chest) begin
        push_seg(it.column, s, e, SHADE_CHEST, 1'b1);
      end else begin
        push_seg(it.column, s, e, side ? SHADE_Y : SHADE_X, 1'b1);
      end
    endfunction

    function void check_segment(out_item_t got);
      out_item_t exp_seg;
      if (segs_due.size() == 0) begin
        $error("segment with no request pending: column %0d", got.out_column);
        errs++;
        return;
      end
      exp_seg = segs_due.pop_front();
      if (got.out_column !== exp_seg.out_column) begin
        $error("out_column: expected %0d, got %0d", exp_seg.out_column, got.out_column);
        errs++;
      end
      if (got.row_start !== exp_seg.row_start) begin
        $error("row_start: expected %0d, got %0d", exp_seg.row_start, got.row_start);
        errs++;
      end
      if (got.row_end !== exp_seg.row_end) begin
        $error("row_end: expected %0d, got %0d", exp_seg.row_end, got.row_end);
        errs++;
      end
      if (got.shade !== exp_seg.shade) begin
        $error("shade: expected %0d, got %0d", exp_seg.shade, got.shade);
        errs++;
      end
      if (got.last !== exp_seg.last) begin
        $error("last: expected %0d, got %0d", exp_seg.last, got.last);
        errs++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [20:0] cfg_wdata;

  column_scoreboard sb;
  bit quiet;
  bit press_req;
  int hold;

  grid_raycast_column u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, and one long hold-off on request from the sender
  initial begin
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (press_req) begin
        press_req = 0;
        hold = 3000;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 9) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_segment(out_data);
  end

  task automatic send_request(in_item_t it);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic maybe_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_cell(int x, int y, int v);
    in_item_t it;
    it = '0;
    it.operation  = OP_WRITE;
    it.cell_x     = 5'(x);
    it.cell_y     = 5'(y);
    it.cell_value = 8'(v);
    it.column     = 8'($urandom);
    send_request(it);
  endtask

  task automatic cast_column(int col);
    in_item_t it;
    it = '0;
    it.operation  = OP_CAST;
    it.cell_x     = 5'($urandom);
    it.cell_y     = 5'($urandom);
    it.cell_value = 8'($urandom);
    it.column     = 8'(col);
    send_request(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [20:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // wait for the last segment, then let queued map writes finish
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.segs_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_camera(int px, int py, int dxv, int dyv, int plx, int ply);
    write_reg(CFG_POS_X, 21'(px));
    write_reg(CFG_POS_Y, 21'(py));
    write_reg(CFG_DIR_X, 21'(dxv & 18'h3FFFF));
    write_reg(CFG_DIR_Y, 21'(dyv & 18'h3FFFF));
    write_reg(CFG_PLANE_X, 21'(plx & 18'h3FFFF));
    write_reg(CFG_PLANE_Y, 21'(ply & 18'h3FFFF));
  endtask

  function automatic int rand_vec();
    case ($urandom_range(0, 7))
      0: return -131072;
      1: return 131071;
      2: return 0;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 2097151;
      2: return $urandom_range(1, 30) << 16;
      default: return $urandom_range(65536, 31 * 65536);
    endcase
  endfunction

  task automatic random_request();
    int v;
    maybe_gap();
    if ($urandom_range(0, 9) < 7) cast_column($urandom_range(0, 255));
    else begin
      case ($urandom_range(0, 4))
        0, 1: v = 0;
        2: v = CHEST_CODE;
        default: v = $urandom_range(1, 255);
      endcase
      write_cell($urandom_range(0, 31), $urandom_range(0, 31), v);
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    press_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset camera, empty map: rays leave the map; center column has zero y
    cast_column(0);
    cast_column(128);
    cast_column(255);
    write_cell(31, 31, 255);
    write_cell(0, 0, 0);
    write_cell(4, 1, CHEST_CODE);
    cast_column(128);
    write_cell(1, 5, 9);
    cast_column(200);
    cast_column(60);
    drain();

    // camera on a cell edge looking back at a wall: zero distance
    set_camera(2 << 16, 163840, -65536, 0, 0, 0);
    write_cell(1, 2, 7);
    cast_column(17);
    drain();

    // diagonal ray from a cell center: tie between x and y
    set_camera(10 << 16 | 32768, 10 << 16 | 32768, 65536, 65536, 0, 0);
    cast_column(0);
    drain();
    // position zero with negative rays
    set_camera(0, 0, -131072, -131072, 0, 0);
    cast_column(255);
    drain();

    // very short ray: saturated distance, chest with a tiny line
    set_camera(98304, 98304, 100, 0, 0, 0);
    write_cell(2, 1, CHEST_CODE);
    cast_column(5);
    drain();
    set_camera(2097151, 2097151, 131071, 131071, -131072, 131071);
    cast_column(255);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      set_camera(rand_pos(), rand_pos(), rand_vec(), rand_vec(), rand_vec(), rand_vec());
      if (ph == 3) begin
        press_req = 1;
        for (int i = 0; i < 10; i++) cast_column($urandom_range(0, 255));
      end
      if (ph == 6) quiet = 1;
      for (int i = 0; i < 45; i++) random_request();
      drain();
    end

    if (sb.errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* grid_raycast_column.f */
sv/grc_pkg.sv
sv/grc_ram.sv
sv/grc_div.sv
sv/grc_front.sv
sv/grc_back.sv
sv/grid_raycast_column.sv
tb/tb_grid_raycast_column.sv
